FILE: rtl/core/hrlp_pkg.sv
// types, constants and reset values shared by the request line parser
package hrlp_pkg;

    localparam int MAX_PATH   = 1024;
    localparam int CNT_W      = $clog2(MAX_PATH + 1);
    localparam int PATH_LEN_W = 11;

    typedef enum logic [2:0] {
        PH_BEFORE_METHOD  = 3'd0,
        PH_METHOD         = 3'd1,
        PH_BEFORE_PATH    = 3'd2,
        PH_PATH           = 3'd3,
        PH_BEFORE_VERSION = 3'd4,
        PH_VERSION        = 3'd5,
        PH_AFTER          = 3'd6,
        PH_LINE_DONE      = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } esc_t;

    typedef enum logic [1:0] {
        PM_EMIT  = 2'd0,
        PM_QUERY = 2'd1,
        PM_STOP  = 2'd2
    } path_mode_t;

    localparam logic [3:0] ERR_VER  = 4'b0001;
    localparam logic [3:0] ERR_PATH = 4'b0010;
    localparam logic [3:0] ERR_TRAV = 4'b0100;
    localparam logic [3:0] ERR_METH = 4'b1000;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_REQUEST = 2'd1;
    localparam logic [1:0] ST_FORBIDDEN   = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOWED = 2'd3;

    localparam logic [1:0] MK_GET         = 2'd0;
    localparam logic [1:0] MK_HEAD        = 2'd1;
    localparam logic [1:0] MK_UNSUPPORTED = 2'd2;

    localparam logic [1:0] VK_0_9 = 2'd0;
    localparam logic [1:0] VK_1_0 = 2'd1;
    localparam logic [1:0] VK_1_1 = 2'd2;

    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_QUERY   = 8'h3f;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    localparam logic [0:1][3:0]      METHOD_LEN  = '{4'd3, 4'd4};
    localparam logic [0:1][0:3][7:0] METHOD_TEXT = '{{"GET", 8'h00}, "HEAD"};
    localparam logic [0:2][0:7][7:0] VERSION_TEXT = '{"HTTP/0.9", "HTTP/1.0", "HTTP/1.1"};

    typedef struct packed {
        phase_t           token_phase;
        logic [3:0]       token_position;
        logic [1:0]       method_match;
        logic [2:0]       version_match;
        esc_t             escape_phase;
        logic [3:0]       high_nibble;
        logic [15:0]      recent_decoded;
        logic [3:0]       error_flags;
        path_mode_t       path_mode;
        logic [CNT_W-1:0] path_count;
    } state_t;

    localparam state_t STATE_INIT = '{
        token_phase:    PH_BEFORE_METHOD,
        token_position: 4'd0,
        method_match:   2'b11,
        version_match:  3'b111,
        escape_phase:   ESC_NONE,
        high_nibble:    4'd0,
        recent_decoded: 16'd0,
        error_flags:    4'd0,
        path_mode:      PM_EMIT,
        path_count:     '0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_request;
    } req_t;

    typedef struct packed {
        logic [7:0]            path_byte;
        logic                  path_valid;
        logic                  done_res;
        logic [1:0]            status_code;
        logic [1:0]            method_kind;
        logic [1:0]            version_kind;
        logic [PATH_LEN_W-1:0] path_length;
    } res_t;

    typedef struct packed {
        state_t next_state;
        logic   produce;
        res_t   res;
    } step_out_t;

endpackage

FILE: rtl/core/hrlp_input_stage.sv
// input register holding one request byte transaction
module hrlp_input_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  hrlp_pkg::req_t req_data,
    input  logic          take,
    output logic          held_valid,
    output hrlp_pkg::req_t held_data
);

    logic           valid_reg;
    hrlp_pkg::req_t data_reg;

    assign req_ready  = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req_valid && req_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            data_reg <= req_data;
        end
    end

endmodule

FILE: rtl/core/hrlp_step.sv
// next-state and result logic for one request byte
module hrlp_step (
    input  hrlp_pkg::state_t    cur_state,
    input  hrlp_pkg::req_t      item,
    output hrlp_pkg::step_out_t step
);

    typedef struct packed {
        hrlp_pkg::state_t st;
        logic             ev;
        logic [7:0]       eb;
    } work_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
        begin
            r = {1'b1, 4'(c - "0")};
        end
        else if (c >= "a" && c <= "f")
        begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end
        else if (c >= "A" && c <= "F")
        begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

    function automatic work_t take_decoded(input work_t wi, input logic [7:0] d);
        work_t w;
        w = wi;
        if (w.st.path_mode != hrlp_pkg::PM_STOP)
        begin
            if (d == hrlp_pkg::CH_NUL)
            begin
                w.st.path_mode = hrlp_pkg::PM_STOP;
            end
            else
            begin
                if (w.st.recent_decoded[15:8] == hrlp_pkg::CH_DOT
                    && w.st.recent_decoded[7:0] == hrlp_pkg::CH_DOT
                    && d == hrlp_pkg::CH_SLASH)
                begin
                    w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_TRAV;
                end
                w.st.recent_decoded = {w.st.recent_decoded[7:0], d};
                if (w.st.path_mode == hrlp_pkg::PM_EMIT)
                begin
                    if (d == hrlp_pkg::CH_QUERY)
                    begin
                        w.st.path_mode = hrlp_pkg::PM_QUERY;
                    end
                    else if (w.st.path_count >= hrlp_pkg::CNT_W'(hrlp_pkg::MAX_PATH))
                    begin
                        w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_PATH;
                        w.st.path_mode   = hrlp_pkg::PM_STOP;
                    end
                    else
                    begin
                        w.ev            = 1'b1;
                        w.eb            = d;
                        w.st.path_count = w.st.path_count + 1'b1;
                    end
                end
            end
        end
        return w;
    endfunction

    function automatic work_t path_byte_in(input work_t wi, input logic [7:0] c);
        work_t      w;
        logic [4:0] h;
        w = wi;
        h = hex_value(c);
        if (w.st.token_position == 4'd0 && c != hrlp_pkg::CH_SLASH)
        begin
            w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_PATH;
        end
        if ((w.st.error_flags & hrlp_pkg::ERR_PATH) != 4'd0)
        begin
            w.st.escape_phase = hrlp_pkg::ESC_NONE;
        end
        else if (w.st.escape_phase == hrlp_pkg::ESC_HIGH
                 || w.st.escape_phase == hrlp_pkg::ESC_LOW)
        begin
            if (!h[4])
            begin
                w.st.error_flags  = w.st.error_flags | hrlp_pkg::ERR_PATH;
                w.st.escape_phase = hrlp_pkg::ESC_NONE;
                w.st.path_mode    = hrlp_pkg::PM_STOP;
            end
            else if (w.st.escape_phase == hrlp_pkg::ESC_HIGH)
            begin
                w.st.high_nibble  = h[3:0];
                w.st.escape_phase = hrlp_pkg::ESC_LOW;
            end
            else
            begin
                w.st.escape_phase = hrlp_pkg::ESC_NONE;
                w = take_decoded(w, {w.st.high_nibble, h[3:0]});
            end
        end
        else if (c == hrlp_pkg::CH_PERCENT)
        begin
            w.st.escape_phase = hrlp_pkg::ESC_HIGH;
        end
        else
        begin
            w = take_decoded(w, (c == hrlp_pkg::CH_PLUS) ? hrlp_pkg::CH_SPACE : c);
        end
        return w;
    endfunction

    function automatic work_t token_byte(input work_t wi, input logic [7:0] c);
        work_t w;
        w = wi;
        if (w.st.token_phase == hrlp_pkg::PH_METHOD)
        begin
            for (int k = 0; k < 2; k++)
            begin
                if (!(w.st.token_position < hrlp_pkg::METHOD_LEN[k]
                      && c == hrlp_pkg::METHOD_TEXT[k][w.st.token_position[1:0]]))
                begin
                    w.st.method_match[k] = 1'b0;
                end
            end
        end
        else if (w.st.token_phase == hrlp_pkg::PH_PATH)
        begin
            w = path_byte_in(w, c);
        end
        else if (w.st.token_phase == hrlp_pkg::PH_VERSION)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!(!w.st.token_position[3]
                      && c == hrlp_pkg::VERSION_TEXT[k][w.st.token_position[2:0]]))
                begin
                    w.st.version_match[k] = 1'b0;
                end
            end
        end
        if (w.st.token_position != 4'd15)
        begin
            w.st.token_position = w.st.token_position + 4'd1;
        end
        return w;
    endfunction

    function automatic work_t finish_token(input work_t wi);
        work_t w;
        w = wi;
        if (w.st.token_phase == hrlp_pkg::PH_METHOD)
        begin
            if (w.st.token_position != 4'd3)
            begin
                w.st.method_match[0] = 1'b0;
            end
            if (w.st.token_position != 4'd4)
            begin
                w.st.method_match[1] = 1'b0;
            end
            if (w.st.method_match == 2'b00)
            begin
                w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_METH;
            end
        end
        else if (w.st.token_phase == hrlp_pkg::PH_PATH)
        begin
            if (w.st.escape_phase != hrlp_pkg::ESC_NONE)
            begin
                w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_PATH;
            end
            w.st.escape_phase = hrlp_pkg::ESC_NONE;
        end
        else if (w.st.token_phase == hrlp_pkg::PH_VERSION)
        begin
            if (w.st.token_position != 4'd8)
            begin
                w.st.version_match = 3'b000;
            end
            if (w.st.version_match == 3'b000)
            begin
                w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_VER;
            end
        end
        return w;
    endfunction

    function automatic work_t close_line(input work_t wi);
        work_t            w;
        hrlp_pkg::phase_t p;
        w = wi;
        p = w.st.token_phase;
        w = finish_token(w);
        if (p <= hrlp_pkg::PH_BEFORE_VERSION)
        begin
            w.st.error_flags   = w.st.error_flags | hrlp_pkg::ERR_VER;
            w.st.version_match = 3'b000;
        end
        if (p <= hrlp_pkg::PH_BEFORE_PATH)
        begin
            w.st.error_flags = w.st.error_flags | hrlp_pkg::ERR_PATH;
        end
        if (p == hrlp_pkg::PH_BEFORE_METHOD)
        begin
            w.st.method_match = 2'b00;
        end
        w.st.token_phase = hrlp_pkg::PH_LINE_DONE;
        return w;
    endfunction

    function automatic hrlp_pkg::phase_t phase_after(input hrlp_pkg::phase_t p);
        hrlp_pkg::phase_t r;
        unique case (p)
            hrlp_pkg::PH_BEFORE_METHOD:  r = hrlp_pkg::PH_METHOD;
            hrlp_pkg::PH_METHOD:         r = hrlp_pkg::PH_BEFORE_PATH;
            hrlp_pkg::PH_BEFORE_PATH:    r = hrlp_pkg::PH_PATH;
            hrlp_pkg::PH_PATH:           r = hrlp_pkg::PH_BEFORE_VERSION;
            hrlp_pkg::PH_BEFORE_VERSION: r = hrlp_pkg::PH_VERSION;
            hrlp_pkg::PH_VERSION:        r = hrlp_pkg::PH_AFTER;
            default:                     r = p;
        endcase
        return r;
    endfunction

    logic [7:0] c;
    logic       last;
    logic       eol;
    work_t      w;

    assign c    = item.data_byte;
    assign last = item.end_of_request;
    assign eol  = (c == hrlp_pkg::CH_CR) || (c == hrlp_pkg::CH_LF) || (c == hrlp_pkg::CH_NUL);

    always_comb
    begin
        w    = '0;
        w.st = cur_state;

        unique case (cur_state.token_phase) inside
            hrlp_pkg::PH_BEFORE_METHOD:
            begin
                if (eol)
                begin
                    if (w.st.token_position != 4'd0)
                    begin
                        w = close_line(w);
                    end
                end
                else if (c == hrlp_pkg::CH_SPACE)
                begin
                    w.st.token_position = 4'd1;
                end
                else
                begin
                    w.st.token_phase    = hrlp_pkg::PH_METHOD;
                    w.st.token_position = 4'd0;
                    w = token_byte(w, c);
                end
            end
            hrlp_pkg::PH_METHOD, hrlp_pkg::PH_PATH, hrlp_pkg::PH_VERSION:
            begin
                if (eol)
                begin
                    w = close_line(w);
                end
                else if (c == hrlp_pkg::CH_SPACE)
                begin
                    w = finish_token(w);
                    w.st.token_phase    = phase_after(cur_state.token_phase);
                    w.st.token_position = 4'd0;
                end
                else
                begin
                    w = token_byte(w, c);
                end
            end
            hrlp_pkg::PH_BEFORE_PATH, hrlp_pkg::PH_BEFORE_VERSION:
            begin
                if (eol)
                begin
                    w = close_line(w);
                end
                else if (c != hrlp_pkg::CH_SPACE)
                begin
                    w.st.token_phase    = phase_after(cur_state.token_phase);
                    w.st.token_position = 4'd0;
                    w = token_byte(w, c);
                end
            end
            hrlp_pkg::PH_AFTER:
            begin
                if (eol)
                begin
                    w = close_line(w);
                end
            end
            default:
            begin
            end
        endcase

        if (last && w.st.token_phase != hrlp_pkg::PH_LINE_DONE)
        begin
            w = close_line(w);
        end

        step.produce            = w.ev || last;
        step.res                = '0;
        step.res.path_byte      = w.eb;
        step.res.path_valid     = w.ev;
        step.res.done_res       = last;
        if (last)
        begin
            if ((w.st.error_flags & (hrlp_pkg::ERR_VER | hrlp_pkg::ERR_PATH)) != 4'd0)
            begin
                step.res.status_code = hrlp_pkg::ST_BAD_REQUEST;
            end
            else if ((w.st.error_flags & hrlp_pkg::ERR_TRAV) != 4'd0)
            begin
                step.res.status_code = hrlp_pkg::ST_FORBIDDEN;
            end
            else if ((w.st.error_flags & hrlp_pkg::ERR_METH) != 4'd0)
            begin
                step.res.status_code = hrlp_pkg::ST_NOT_ALLOWED;
            end
            else
            begin
                step.res.status_code = hrlp_pkg::ST_OK;
            end

            if (w.st.method_match[0])
            begin
                step.res.method_kind = hrlp_pkg::MK_GET;
            end
            else if (w.st.method_match[1])
            begin
                step.res.method_kind = hrlp_pkg::MK_HEAD;
            end
            else
            begin
                step.res.method_kind = hrlp_pkg::MK_UNSUPPORTED;
            end

            if (w.st.version_match[0])
            begin
                step.res.version_kind = hrlp_pkg::VK_0_9;
            end
            else if (w.st.version_match[1])
            begin
                step.res.version_kind = hrlp_pkg::VK_1_0;
            end
            else if (w.st.version_match[2])
            begin
                step.res.version_kind = hrlp_pkg::VK_1_1;
            end
            else
            begin
                step.res.version_kind = hrlp_pkg::VK_0_9;
            end

            step.res.path_length = hrlp_pkg::PATH_LEN_W'(w.st.path_count);
            step.next_state      = hrlp_pkg::STATE_INIT;
        end
        else
        begin
            step.next_state = w.st;
        end
    end

endmodule

FILE: rtl/core/http_request_line_parser.sv
// top level of the http request line parser with path percent-decoding
//
// One request byte transaction can be taken every clock cycle while no result
// waits untaken. A byte passes through an input register and the parse and
// decode logic into the result register, which holds its result until it is
// taken. Bytes that give no result (separators, method and version bytes,
// escape digits) are absorbed without a result transaction; a result is given
// for each emitted path byte and for the byte marked as the end of the request.
// While a result waits, one more byte can enter the input register; the input
// then stalls until the result register is taken, whether or not that byte
// gives a result.
module http_request_line_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  hrlp_pkg::req_t req_data,
    output logic           res_valid,
    input  logic           res_ready,
    output hrlp_pkg::res_t res_data
);

    logic                held_valid;
    hrlp_pkg::req_t      held_data;
    logic                take;
    hrlp_pkg::state_t    state_reg;
    hrlp_pkg::step_out_t step;
    logic                res_valid_reg;
    hrlp_pkg::res_t      res_data_reg;

    assign take = held_valid && (!res_valid_reg || res_ready);

    hrlp_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .take       (take),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    hrlp_step u_step (
        .cur_state (state_reg),
        .item      (held_data),
        .step      (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrlp_pkg::STATE_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                state_reg <= step.next_state;
            end
            if (take && step.produce)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && step.produce)
        begin
            res_data_reg <= step.res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: tb/tb_http_request_line_parser.sv
// self-checking testbench for http_request_line_parser: directed and random requests against a parsing model
module tb_http_request_line_parser;

    import hrlp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 950;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic res_valid;
    logic res_ready;
    res_t res_data;

    http_request_line_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always #1 clk = ~clk;

    // parser model state
    phase_t      ln_phase;
    logic [3:0]  tok_pos;
    logic [1:0]  meth_cand;
    logic [2:0]  ver_cand;
    esc_t        esc_state;
    logic [3:0]  esc_high;
    logic [15:0] last_two;
    logic [3:0]  err_bits;
    path_mode_t  emit_mode;
    int          emitted_len;
    bit          out_valid;
    logic [7:0]  out_byte;

    res_t       decoded_queue[$];
    res_t       next_expected;
    logic [7:0] req_bytes[$];

    bit send_gaps = 1'b1;
    bit take_gaps = 1'b1;
    int mismatches = 0;
    int results_checked = 0;
    int path_bytes_seen = 0;
    int byte_count = 0;
    int requests_sent = 0;
    int cycle_count = 0;
    int status_tally[4];

    function automatic void clear_parser();
        ln_phase    = PH_BEFORE_METHOD;
        tok_pos     = 4'd0;
        meth_cand   = 2'b11;
        ver_cand    = 3'b111;
        esc_state   = ESC_NONE;
        esc_high    = 4'd0;
        last_two    = 16'd0;
        err_bits    = 4'd0;
        emit_mode   = PM_EMIT;
        emitted_len = 0;
    endfunction

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return c - "0";
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    function automatic void accept_decoded(logic [7:0] d);
        if (emit_mode == PM_STOP)
            return;
        if (d == CH_NUL)
        begin
            emit_mode = PM_STOP;
            return;
        end
        if (last_two == {CH_DOT, CH_DOT} && d == CH_SLASH)
            err_bits |= ERR_TRAV;
        last_two = {last_two[7:0], d};
        if (emit_mode != PM_EMIT)
            return;
        if (d == CH_QUERY)
        begin
            emit_mode = PM_QUERY;
            return;
        end
        if (emitted_len >= MAX_PATH)
        begin
            err_bits |= ERR_PATH;
            emit_mode = PM_STOP;
            return;
        end
        out_valid = 1'b1;
        out_byte  = d;
        emitted_len++;
    endfunction

    function automatic void path_char(logic [7:0] c);
        int h;
        if (tok_pos == 0 && c != CH_SLASH)
            err_bits |= ERR_PATH;
        if ((err_bits & ERR_PATH) != 0)
        begin
            esc_state = ESC_NONE;
            return;
        end
        h = hex_nibble(c);
        if (esc_state == ESC_NONE)
        begin
            if (c == CH_PERCENT)
                esc_state = ESC_HIGH;
            else
                accept_decoded(c == CH_PLUS ? CH_SPACE : c);
        end
        else if (h < 0)
        begin
            err_bits |= ERR_PATH;
            esc_state = ESC_NONE;
            emit_mode = PM_STOP;
        end
        else if (esc_state == ESC_HIGH)
        begin
            esc_high  = h[3:0];
            esc_state = ESC_LOW;
        end
        else
        begin
            esc_state = ESC_NONE;
            accept_decoded({esc_high, h[3:0]});
        end
    endfunction

    function automatic void token_char(logic [7:0] c);
        if (ln_phase == PH_METHOD)
        begin
            for (int k = 0; k < 2; k++)
                if (!(tok_pos < METHOD_LEN[k] && c == METHOD_TEXT[k][tok_pos[1:0]]))
                    meth_cand[k] = 1'b0;
        end
        else if (ln_phase == PH_PATH)
        begin
            path_char(c);
        end
        else if (ln_phase == PH_VERSION)
        begin
            for (int k = 0; k < 3; k++)
                if (!(tok_pos < 8 && c == VERSION_TEXT[k][tok_pos[2:0]]))
                    ver_cand[k] = 1'b0;
        end
        if (tok_pos < 15)
            tok_pos++;
    endfunction

    function automatic void end_token();
        case (ln_phase)
            PH_METHOD:
            begin
                if (tok_pos != 3)
                    meth_cand[0] = 1'b0;
                if (tok_pos != 4)
                    meth_cand[1] = 1'b0;
                if (meth_cand == 2'b00)
                    err_bits |= ERR_METH;
            end
            PH_PATH:
            begin
                if (esc_state != ESC_NONE)
                    err_bits |= ERR_PATH;
                esc_state = ESC_NONE;
            end
            PH_VERSION:
            begin
                if (tok_pos != 8)
                    ver_cand = 3'b000;
                if (ver_cand == 3'b000)
                    err_bits |= ERR_VER;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void end_line();
        phase_t p;
        p = ln_phase;
        end_token();
        if (p <= PH_BEFORE_VERSION)
        begin
            err_bits |= ERR_VER;
            ver_cand = 3'b000;
        end
        if (p <= PH_BEFORE_PATH)
            err_bits |= ERR_PATH;
        if (p == PH_BEFORE_METHOD)
            meth_cand = 2'b00;
        ln_phase = PH_LINE_DONE;
    endfunction

    function automatic void parse_request_byte(logic [7:0] c, bit last);
        bit   eol;
        res_t r;
        eol       = (c == CH_CR || c == CH_LF || c == CH_NUL);
        out_valid = 1'b0;
        out_byte  = 8'd0;
        case (ln_phase)
            PH_BEFORE_METHOD:
            begin
                if (eol)
                begin
                    if (tok_pos != 0)
                        end_line();
                end
                else if (c == CH_SPACE)
                begin
                    tok_pos = 4'd1;
                end
                else
                begin
                    ln_phase = PH_METHOD;
                    tok_pos  = 4'd0;
                    token_char(c);
                end
            end
            PH_METHOD, PH_PATH, PH_VERSION:
            begin
                if (eol)
                begin
                    end_line();
                end
                else if (c == CH_SPACE)
                begin
                    end_token();
                    ln_phase = phase_t'(ln_phase + 1);
                    tok_pos  = 4'd0;
                end
                else
                begin
                    token_char(c);
                end
            end
            PH_BEFORE_PATH, PH_BEFORE_VERSION:
            begin
                if (eol)
                begin
                    end_line();
                end
                else if (c != CH_SPACE)
                begin
                    ln_phase = phase_t'(ln_phase + 1);
                    tok_pos  = 4'd0;
                    token_char(c);
                end
            end
            PH_AFTER:
            begin
                if (eol)
                    end_line();
            end
            default:
            begin
            end
        endcase
        if (!out_valid && !last)
            return;
        r            = '0;
        r.path_byte  = out_byte;
        r.path_valid = out_valid;
        if (last)
        begin
            if (ln_phase != PH_LINE_DONE)
                end_line();
            r.done_res = 1'b1;
            if ((err_bits & (ERR_VER | ERR_PATH)) != 0)
                r.status_code = ST_BAD_REQUEST;
            else if ((err_bits & ERR_TRAV) != 0)
                r.status_code = ST_FORBIDDEN;
            else if ((err_bits & ERR_METH) != 0)
                r.status_code = ST_NOT_ALLOWED;
            else
                r.status_code = ST_OK;
            r.method_kind  = meth_cand[0] ? MK_GET : meth_cand[1] ? MK_HEAD : MK_UNSUPPORTED;
            r.version_kind = ver_cand[0] ? VK_0_9 : ver_cand[1] ? VK_1_0 :
                             ver_cand[2] ? VK_1_1 : VK_0_9;
            r.path_length  = emitted_len[PATH_LEN_W-1:0];
            status_tally[r.status_code]++;
            clear_parser();
        end
        decoded_queue.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s is %0h, expected %0h", results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (decoded_queue.size() == 0)
            begin
                report_mismatch("result with nothing pending, path_byte", res_data.path_byte, 0);
            end
            else
            begin
                next_expected = decoded_queue.pop_front();
                check_field("path_byte", res_data.path_byte, next_expected.path_byte);
                check_field("path_valid", res_data.path_valid, next_expected.path_valid);
                check_field("done_res", res_data.done_res, next_expected.done_res);
                check_field("status_code", res_data.status_code, next_expected.status_code);
                check_field("method_kind", res_data.method_kind, next_expected.method_kind);
                check_field("version_kind", res_data.version_kind, next_expected.version_kind);
                check_field("path_length", res_data.path_length, next_expected.path_length);
                if (next_expected.path_valid)
                    path_bytes_seen++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stall before each transaction
    initial
    begin
        int pause;
        res_ready = 1'b0;
        forever
        begin
            pause = take_gaps ? $urandom_range(0, 9) : 0;
            repeat (pause)
            begin
                @(negedge clk);
                res_ready = 1'b0;
            end
            @(negedge clk);
            res_ready = 1'b1;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    task automatic send_byte(logic [7:0] c, bit last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = '{data_byte: c, end_of_request: last};
        do
            @(posedge clk);
        while (!req_ready);
        parse_request_byte(c, last);
        byte_count++;
    endtask

    task automatic send_request();
        int n;
        n = req_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(req_bytes[i], i == n - 1);
        req_bytes.delete();
        requests_sent++;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            req_bytes.push_back(s[i]);
    endfunction

    task automatic request(string s);
        add_text(s);
        send_request();
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 10)
            return 8'h30 + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic void add_escape(logic [7:0] v);
        req_bytes.push_back(CH_PERCENT);
        req_bytes.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
        req_bytes.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
    endfunction

    function automatic void add_separator();
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1)
            req_bytes.push_back(CH_SPACE);
    endfunction

    task automatic wait_for_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (decoded_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic test_methods_and_versions();
        request("GET / HTTP/1.1\r\n");
        request("HEAD /index.html HTTP/1.0\r\n");
        request("GET /a HTTP/0.9");
        request("POST /x HTTP/1.1\r\n");
        request("GETS / HTTP/1.1\n");
        request("GET / HTTP/2.0\r\n");
        request("GET / HTTP/1.12\r\n");
        request("GET /a\r\n");
    endtask

    task automatic test_path_decoding();
        request("GET /a%20b+c%7E HTTP/1.1\r\n");
        request("GET /%41%6a%6A%fF HTTP/1.0\r\n");
        request("GET /%G1x HTTP/1.1\r\n");
        request("GET /abc% HTTP/1.1\r\n");
        request("GET /ab%4");
        request("GET /%00abc%zz HTTP/1.1\r\n");
        request("GET /x?y=1&z HTTP/1.1\r\n");
        request("GET /a/../b HTTP/1.1\r\n");
        request("GET /%2e%2e%2fetc HTTP/1.1\r\n");
        request("HEAD /q?a=../ HTTP/1.1\r\n");
        request("GET abc HTTP/1.1\r\n");
        request("GET %2fabc HTTP/1.1\r\n");
        add_text("GET /");
        req_bytes.push_back(8'hff);
        req_bytes.push_back(8'h80);
        req_bytes.push_back(8'h7f);
        add_text(" HTTP/1.1\r\n");
        send_request();
    endtask

    task automatic test_line_boundaries();
        request("\r\n\r\nGET / HTTP/1.1\r\n");
        request("  GET  /b   HTTP/1.0  extra more\r\n");
        request("\r");
        req_bytes.push_back(CH_NUL);
        send_request();
        request("   ");
        request("GET / HTTP/1.1\r\nHost: a\r\n\r\n");
        add_text("GET /a");
        req_bytes.push_back(CH_NUL);
        add_text(" HTTP/1.1");
        send_request();
        request("GET");
    endtask

    // sender holds off until the pipeline is empty, then long paths back to back
    task automatic test_path_limit();
        wait_for_results();
        send_gaps = 1'b0;
        add_text("GET /");
        repeat (MAX_PATH - 1) req_bytes.push_back("a");
        add_text(" HTTP/1.1\r\n");
        send_request();
        add_text("HEAD /");
        repeat (MAX_PATH) req_bytes.push_back("b");
        add_text("?q HTTP/1.0\r\n");
        send_request();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_requests();
        int         goal;
        int         kind;
        int         r;
        int         cut;
        int         at;
        string      pool;
        logic [7:0] special[4];
        pool    = "abcdefxyzABZ0129-_.~/=&";
        special = '{CH_DOT, CH_SLASH, CH_QUERY, CH_NUL};
        goal    = byte_count + RANDOM_BYTES;
        while (byte_count < goal)
        begin
            send_gaps = ($urandom_range(0, 3) != 0);
            take_gaps = ($urandom_range(0, 3) != 0);
            kind      = $urandom_range(0, 99);
            if (kind >= 90)
            begin
                repeat ($urandom_range(1, 12))
                    req_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    add_text("\r\n");
                else if (r == 1)
                    req_bytes.push_back(CH_SPACE);
                r = $urandom_range(0, 9);
                if (r < 4)
                    add_text("GET");
                else if (r < 7)
                    add_text("HEAD");
                else if (r == 7)
                    add_text("get");
                else if (r == 8)
                    add_text("POST");
                else
                    repeat ($urandom_range(1, 5))
                        req_bytes.push_back(8'($urandom_range(8'h41, 8'h5a)));
                add_separator();
                if ($urandom_range(0, 19) == 0)
                    req_bytes.push_back(pool[$urandom_range(0, 15)]);
                else
                    req_bytes.push_back(CH_SLASH);
                repeat ($urandom_range(0, 10))
                begin
                    r = $urandom_range(0, 19);
                    if (r < 8)
                        req_bytes.push_back(pool[$urandom_range(0, pool.len() - 1)]);
                    else if (r < 10)
                        add_escape(8'($urandom_range(0, 255)));
                    else if (r == 10)
                        add_escape(special[$urandom_range(0, 3)]);
                    else if (r == 11)
                        req_bytes.push_back(CH_PLUS);
                    else if (r == 12)
                        req_bytes.push_back(CH_QUERY);
                    else if (r == 13)
                        add_text("../");
                    else if (r == 14)
                        add_text("..");
                    else if (r == 15)
                    begin
                        req_bytes.push_back(CH_PERCENT);
                        if ($urandom_range(0, 1))
                            req_bytes.push_back("g");
                    end
                    else if (r == 16)
                        req_bytes.push_back(8'($urandom_range(128, 255)));
                    else
                        req_bytes.push_back(CH_SLASH);
                end
                add_separator();
                r  = $urandom_range(0, 9);
                at = req_bytes.size();
                if (r < 3)
                    add_text("HTTP/1.1");
                else if (r < 5)
                    add_text("HTTP/1.0");
                else if (r < 7)
                    add_text("HTTP/0.9");
                else if (r == 7)
                    add_text("HTTP/1.");
                else if (r == 8)
                begin
                    add_text("HTTP/1.1");
                    req_bytes[at + $urandom_range(0, 7)] = 8'($urandom_range(33, 126));
                end
                case ($urandom_range(0, 6))
                    0: add_text("\r\n");
                    1: add_text("\n");
                    2: add_text("\r");
                    3: add_text("\r\nHost: h\r\n\r\n");
                    4: add_text(" x y\r\n");
                    5: req_bytes.push_back(CH_NUL);
                    default:
                    begin
                    end
                endcase
                if (kind >= 75)
                begin
                    cut = $urandom_range(1, req_bytes.size());
                    while (req_bytes.size() > cut)
                        void'(req_bytes.pop_back());
                end
            end
            send_request();
        end
        send_gaps = 1'b1;
        take_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        clear_parser();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_methods_and_versions();
        test_path_decoding();
        test_line_boundaries();
        test_path_limit();
        test_random_requests();

        wait_for_results();
        repeat (8) @(negedge clk);
        $display("%0d requests, %0d bytes sent, %0d results checked (%0d path bytes)",
                 requests_sent, byte_count, results_checked, path_bytes_seen);
        $display("final status mix: ok %0d, bad request %0d, forbidden %0d, not allowed %0d",
                 status_tally[ST_OK], status_tally[ST_BAD_REQUEST],
                 status_tally[ST_FORBIDDEN], status_tally[ST_NOT_ALLOWED]);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
